### rtl/iir_filter_direct_form_one_macros.svh
// ---------------------------------------------------------------------------
// IIR filter assertion macros
// Clocked assertion shorthands for the checker file of the filter.
// ---------------------------------------------------------------------------
`ifndef IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH

// Assertion that is switched off while reset is high.
`define IIR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define IIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/iir_pkg.sv
// ---------------------------------------------------------------------------
// IIR filter package
// Shared constants, register indexes and types of the direct form I filter.
// ---------------------------------------------------------------------------
package iir_pkg;

   localparam int COEF_BITS      = 18;
   localparam int NUM_B_REGS     = 5;
   localparam int NUM_A_REGS     = 3;
   localparam int IN_DEPTH       = 4;
   localparam int OUT_DEPTH      = 3;
   localparam int CSR_INDEX_BITS = 3;

   localparam int DEF_NUM_FEEDFORWARD = 5;
   localparam int DEF_NUM_FEEDBACK    = 3;
   localparam int DEF_SAMPLE_BITS     = 16;
   localparam int DEF_COEF_FRAC_BITS  = 14;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COEF_B0 = 3'd0,
      REG_COEF_B1 = 3'd1,
      REG_COEF_B2 = 3'd2,
      REG_COEF_B3 = 3'd3,
      REG_COEF_B4 = 3'd4,
      REG_COEF_A1 = 3'd5,
      REG_COEF_A2 = 3'd6,
      REG_COEF_A3 = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [NUM_B_REGS-1:0][COEF_BITS-1:0] b;
      logic [NUM_A_REGS-1:0][COEF_BITS-1:0] a;
   } coef_set_type;

   typedef struct packed {
      logic load_in;
      logic advance;
   } pipe_ctrl_type;

endpackage

### rtl/iir_channels_if.sv
// ---------------------------------------------------------------------------
// IIR filter channels
// Valid/ready channels for input samples and filtered results.
// ---------------------------------------------------------------------------
interface iir_req_if
   import iir_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          clear_history;

   modport source (output valid, output sample_in, output clear_history, input ready);
   modport sink   (input valid, input sample_in, input clear_history, output ready);
endinterface

interface iir_rsp_if
   import iir_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          saturated;

   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

### rtl/iir_coef_regs.sv
// ---------------------------------------------------------------------------
// IIR coefficient registers
// Holds the feedforward and feedback coefficients written through the CSR port.
// ---------------------------------------------------------------------------
module iir_coef_regs
   import iir_pkg::*;
#(
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]      csr_wdata,
   output coef_set_type              coefs
);
   localparam longint COEF_MAX  = (longint'(1) << (COEF_BITS - 1)) - 1;
   localparam longint UNITY     = longint'(1) << COEF_FRAC_BITS;
   localparam logic [COEF_BITS-1:0] B0_RESET =
      COEF_BITS'((UNITY > COEF_MAX) ? COEF_MAX : UNITY);
   localparam coef_set_type COEF_RESET = coef_set_type'({
      {((NUM_B_REGS - 1) * COEF_BITS){1'b0}},
      B0_RESET,
      {(NUM_A_REGS * COEF_BITS){1'b0}}
   });

   coef_set_type coefs_ff;
   coef_set_type coefs_in;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_COEF_B0: coefs_in.b[0] = csr_wdata;
            REG_COEF_B1: coefs_in.b[1] = csr_wdata;
            REG_COEF_B2: coefs_in.b[2] = csr_wdata;
            REG_COEF_B3: coefs_in.b[3] = csr_wdata;
            REG_COEF_B4: coefs_in.b[4] = csr_wdata;
            REG_COEF_A1: coefs_in.a[0] = csr_wdata;
            REG_COEF_A2: coefs_in.a[1] = csr_wdata;
            REG_COEF_A3: coefs_in.a[2] = csr_wdata;
            default:     coefs_in = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= COEF_RESET;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;
endmodule

### rtl/iir_datapath.sv
// ---------------------------------------------------------------------------
// IIR datapath
// Input register, sample histories, multiply-accumulate, rounding and
// saturation into the result register.
// ---------------------------------------------------------------------------
module iir_datapath
   import iir_pkg::*;
#(
   parameter int NUM_FEEDFORWARD = DEF_NUM_FEEDFORWARD,
   parameter int NUM_FEEDBACK    = DEF_NUM_FEEDBACK,
   parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pipe_ctrl_type                 ctrl,
   input  coef_set_type                  coefs,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic                          clear_history,
   output logic signed [SAMPLE_BITS-1:0] sample_out,
   output logic                          saturated
);
   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + 4;
   localparam int NUM_TERMS = 1 + IN_DEPTH + OUT_DEPTH;
   localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] SMAX = (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [ACC_BITS-1:0] SMIN = -SMAX - 1;

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          clr_ff;
   logic signed [SAMPLE_BITS-1:0] hist_x_ff [IN_DEPTH];
   logic signed [SAMPLE_BITS-1:0] hist_y_ff [OUT_DEPTH];
   logic signed [SAMPLE_BITS-1:0] sample_out_ff;
   logic                          saturated_ff;

   logic signed [SAMPLE_BITS-1:0] hx_eff [IN_DEPTH];
   logic signed [SAMPLE_BITS-1:0] hy_eff [OUT_DEPTH];
   logic signed [PROD_BITS-1:0]   prod_b [IN_DEPTH+1];
   logic signed [PROD_BITS-1:0]   prod_a [OUT_DEPTH];
   logic signed [ACC_BITS-1:0]    term [NUM_TERMS];
   logic signed [ACC_BITS-1:0]    sum_lo;
   logic signed [ACC_BITS-1:0]    sum_hi;
   logic signed [ACC_BITS-1:0]    acc;
   logic signed [ACC_BITS-1:0]    rounded;
   logic signed [ACC_BITS-1:0]    q_full;
   logic signed [SAMPLE_BITS-1:0] sample_out_in;
   logic                          saturated_in;

   always_comb begin
      for (int i = 0; i < IN_DEPTH; i++) begin
         hx_eff[i] = clr_ff ? '0 : hist_x_ff[i];
      end
      for (int i = 0; i < OUT_DEPTH; i++) begin
         hy_eff[i] = clr_ff ? '0 : hist_y_ff[i];
      end
   end

   always_comb begin
      prod_b[0] = signed'(coefs.b[0]) * x_ff;
      for (int m = 1; m <= IN_DEPTH; m++) begin
         prod_b[m] = signed'(coefs.b[m]) * hx_eff[m-1];
      end
      for (int m = 0; m < OUT_DEPTH; m++) begin
         prod_a[m] = signed'(coefs.a[m]) * hy_eff[m];
      end
   end

   always_comb begin
      term[0] = ACC_BITS'(prod_b[0]);
      for (int m = 1; m <= IN_DEPTH; m++) begin
         term[m] = (m < NUM_FEEDFORWARD) ? ACC_BITS'(prod_b[m]) : '0;
      end
      for (int m = 0; m < OUT_DEPTH; m++) begin
         term[1+IN_DEPTH+m] = (m < NUM_FEEDBACK) ? -ACC_BITS'(prod_a[m]) : '0;
      end
   end

   assign sum_lo  = (term[0] + term[1]) + (term[2] + term[3]);
   assign sum_hi  = (term[4] + term[5]) + (term[6] + term[7]);
   assign acc     = sum_lo + sum_hi;
   assign rounded = acc + HALF;
   assign q_full  = rounded >>> COEF_FRAC_BITS;

   always_comb begin
      if (q_full > SMAX) begin
         sample_out_in = SMAX[SAMPLE_BITS-1:0];
         saturated_in  = 1'b1;
      end else if (q_full < SMIN) begin
         sample_out_in = SMIN[SAMPLE_BITS-1:0];
         saturated_in  = 1'b1;
      end else begin
         sample_out_in = q_full[SAMPLE_BITS-1:0];
         saturated_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_in) begin
         x_ff   <= sample_in;
         clr_ff <= clear_history;
      end
      if (ctrl.advance) begin
         sample_out_ff <= sample_out_in;
         saturated_ff  <= saturated_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IN_DEPTH; i++) begin
            hist_x_ff[i] <= '0;
         end
         for (int i = 0; i < OUT_DEPTH; i++) begin
            hist_y_ff[i] <= '0;
         end
      end else if (ctrl.advance) begin
         hist_x_ff[0] <= x_ff;
         for (int i = 1; i < IN_DEPTH; i++) begin
            hist_x_ff[i] <= hx_eff[i-1];
         end
         hist_y_ff[0] <= sample_out_in;
         for (int i = 1; i < OUT_DEPTH; i++) begin
            hist_y_ff[i] <= hy_eff[i-1];
         end
      end
   end

   assign sample_out = sample_out_ff;
   assign saturated  = saturated_ff;
endmodule

### rtl/iir_filter_direct_form_one.sv
// An accepted sample waits in the input register until the result register is free.
// Throughput: one sample per cycle unless rsp_ch.ready stalls the result register;
// the feedback path closes through the output history, which updates as a sample
// enters the result register. Reset clears both histories and the pipeline, sets
// coef_b0 to unity and the other coefficients to zero.
// ---------------------------------------------------------------------------
// Direct form I IIR filter
// Two-register pipeline around a single-pass multiply-accumulate datapath.
// ---------------------------------------------------------------------------
module iir_filter_direct_form_one
   import iir_pkg::*;
#(
   parameter int NUM_FEEDFORWARD = DEF_NUM_FEEDFORWARD,
   parameter int NUM_FEEDBACK    = DEF_NUM_FEEDBACK,
   parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   iir_req_if.sink                   req_ch,
   iir_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]      csr_wdata
);
   coef_set_type  coefs;
   pipe_ctrl_type ctrl;
   logic          in_valid_ff;
   logic          in_valid_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic          out_free;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign ctrl.load_in = req_ch.valid && req_ch.ready;
   assign ctrl.advance = in_valid_ff && out_free;

   assign in_valid_in  = ctrl.load_in || (in_valid_ff && !ctrl.advance);
   assign out_valid_in = ctrl.advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;

   iir_coef_regs #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coefs     (coefs)
   );

   iir_datapath #(
      .NUM_FEEDFORWARD (NUM_FEEDFORWARD),
      .NUM_FEEDBACK    (NUM_FEEDBACK),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .COEF_FRAC_BITS  (COEF_FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .coefs         (coefs),
      .sample_in     (req_ch.sample_in),
      .clear_history (req_ch.clear_history),
      .sample_out    (rsp_ch.sample_out),
      .saturated     (rsp_ch.saturated)
   );
endmodule

### rtl/iir_checker.sv
// ---------------------------------------------------------------------------
// IIR filter checker
// Port-level assertions on the filter, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "iir_filter_direct_form_one_macros.svh"

module iir_checker
   import iir_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_saturated
);
   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   `IIR_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result after reset")
   `IIR_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out), "stalled result changed")
   `IIR_ASSERT(a_sat_at_rail, clock, reset, rsp_valid && rsp_saturated |-> rsp_sample_out == SMAX || rsp_sample_out == SMIN, "saturated result off the rails")
   `IIR_ASSERT(a_empty_ready, clock, reset, !rsp_valid |-> req_ready, "empty pipeline refuses a transaction")
endmodule

bind iir_filter_direct_form_one iir_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_iir_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_sample_out (rsp_ch.sample_out),
   .rsp_saturated  (rsp_ch.saturated)
);
